// ===== rtl/cfir_pkg.sv =====
// shared constants and types for the complex fir filter
`timescale 1ns / 1ps

package cfir_pkg;

  // default sizes of the filter
  localparam int MAX_TAPS_DEF    = 64;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int COEF_BITS_DEF   = 16;

  // fixed field and register widths
  localparam int TAP_COUNT_W    = 7;
  localparam int OUTPUT_SHIFT_W = 5;
  localparam int COEF_INDEX_W   = 6;
  localparam int CFG_DATA_W     = 7;
  localparam int CFG_INDEX_W    = 1;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_TAP_COUNT    = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_OUTPUT_SHIFT = 1'd1;

  // register reset values
  localparam logic [TAP_COUNT_W-1:0]    TAP_COUNT_RST    = 7'd33;
  localparam logic [OUTPUT_SHIFT_W-1:0] OUTPUT_SHIFT_RST = 5'd14;

  // input word kinds
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_COEF   = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAC,
    S_DRAIN,
    S_ROUND,
    S_CLIP
  } state_t;

endpackage

// ===== rtl/complex_fir_filter.sv =====
// complex-input fir filter with real coefficients and one shared mac unit
// a sample word runs through the mac pass, drain, round and clip states into the output register
// a new word is taken only in idle, once the last result is loaded; tap_count (clipped to 1..MAX_TAPS)
//   sets the length of the single multiply-accumulate pass over the delay line, one tap a cycle
// a coefficient write gives no result word
// reset: synchronous, clears control, registers and the per-entry valid bits
`timescale 1ns / 1ps

module complex_fir_filter #(
  parameter int MAX_TAPS    = cfir_pkg::MAX_TAPS_DEF,
  parameter int SAMPLE_BITS = cfir_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_BITS   = cfir_pkg::COEF_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // configuration write port
  input  logic                                 cfg_write,
  input  logic [cfir_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [cfir_pkg::CFG_DATA_W-1:0]      cfg_data,
  // input channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 kind,
  input  logic signed [SAMPLE_BITS-1:0]        sample_i,
  input  logic signed [SAMPLE_BITS-1:0]        sample_q,
  input  logic [cfir_pkg::COEF_INDEX_W-1:0]    coef_index,
  input  logic signed [COEF_BITS-1:0]          coef_value,
  // output channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [SAMPLE_BITS-1:0]        out_i,
  output logic signed [SAMPLE_BITS-1:0]        out_q,
  output logic                                 saturated
);

  import cfir_pkg::*;

  // address width of the delay line and coefficient memories
  localparam int AW     = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  // tap counter holds 1..MAX_TAPS
  localparam int CW     = $clog2(MAX_TAPS + 1);
  localparam int CMP_W  = ((CW > TAP_COUNT_W) ? CW : TAP_COUNT_W) + 1;
  localparam int PROD_W = SAMPLE_BITS + COEF_BITS;
  // accumulator: product plus growth over the taps, and room for a 31-bit rounding term
  localparam int SUM_W  = PROD_W + CW + 1;
  localparam int ACC_W  = ((SUM_W > 32) ? SUM_W : 32) + 1;
  localparam int HW     = 2 * SAMPLE_BITS;

  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

  // configuration registers
  logic [TAP_COUNT_W-1:0]    tap_count;
  logic [OUTPUT_SHIFT_W-1:0] output_shift;

  // delay line as a ring buffer, newest sample at wr_ptr
  logic [HW-1:0]              hist_mem [MAX_TAPS];
  logic [MAX_TAPS-1:0]        hist_vld;
  logic [COEF_BITS-1:0]       coef_mem [MAX_TAPS];
  logic [MAX_TAPS-1:0]        coef_vld;
  logic [AW-1:0]              wr_ptr;
  logic [AW-1:0]              wr_ptr_next;

  // sequencer
  state_t                     state;
  state_t                     state_next;
  logic [AW-1:0]              rd_ptr;
  logic [AW-1:0]              coef_ptr;    // tap position, 0 for the newest sample
  logic [CW-1:0]              issue_left;
  logic [CW-1:0]              taps_eff;
  logic [CMP_W-1:0]           tc_ext;

  // mac pipeline
  logic                       rd_ok;       // read data stage holds a tap
  logic                       prod_ok;     // product stage holds a tap
  logic [HW-1:0]              hist_rd;
  logic                       hist_rd_vld;
  logic [COEF_BITS-1:0]       coef_rd;
  logic                       coef_rd_vld;
  logic signed [SAMPLE_BITS-1:0] tap_i;
  logic signed [SAMPLE_BITS-1:0] tap_q;
  logic signed [COEF_BITS-1:0]   tap_c;
  logic signed [PROD_W-1:0]   prod_i;
  logic signed [PROD_W-1:0]   prod_q;
  logic signed [ACC_W-1:0]    acc_i;
  logic signed [ACC_W-1:0]    acc_q;

  // final scaling
  logic signed [ACC_W-1:0]    round_term;
  logic signed [ACC_W-1:0]    shift_i;
  logic signed [ACC_W-1:0]    shift_q;
  logic signed [SAMPLE_BITS-1:0] sat_i;
  logic signed [SAMPLE_BITS-1:0] sat_q;
  logic                       clip_i;
  logic                       clip_q;

  // handshake and strobes
  logic                       in_take;
  logic                       take_sample;
  logic                       take_coef;
  logic                       issue_en;
  logic                       round_en;
  logic                       out_load;

  assign in_take     = in_valid && !in_stall;
  assign take_sample = in_take && (kind == KIND_SAMPLE);
  assign take_coef   = in_take && (kind == KIND_COEF) && (32'(coef_index) < MAX_TAPS);
  assign wr_ptr_next = (wr_ptr == AW'(MAX_TAPS - 1)) ? '0 : wr_ptr + AW'(1);

  // tap_count of zero acts as one tap, above MAX_TAPS acts as MAX_TAPS
  assign tc_ext = CMP_W'(tap_count);
  always_comb begin
    if (tc_ext == '0) begin
      taps_eff = CW'(1);
    end else if (tc_ext > CMP_W'(MAX_TAPS)) begin
      taps_eff = CW'(MAX_TAPS);
    end else begin
      taps_eff = CW'(tc_ext);
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count    <= TAP_COUNT_RST;
      output_shift <= OUTPUT_SHIFT_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_TAP_COUNT:    tap_count    <= cfg_data[TAP_COUNT_W-1:0];
        REG_OUTPUT_SHIFT: output_shift <= cfg_data[OUTPUT_SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (take_sample) begin
          state_next = S_MAC;
        end
      end
      S_MAC: begin
        if (issue_left == CW'(1)) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // last product has been added once both stages are empty
        if (!rd_ok && !prod_ok) begin
          state_next = S_ROUND;
        end
      end
      S_ROUND: state_next = S_CLIP;
      S_CLIP: begin
        if (!out_valid || !out_stall) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall = 1'b1;
    issue_en = 1'b0;
    round_en = 1'b0;
    out_load = 1'b0;
    case (state)
      S_IDLE:  in_stall = 1'b0;
      S_MAC:   issue_en = 1'b1;
      S_DRAIN: ;
      S_ROUND: round_en = 1'b1;
      S_CLIP:  out_load = !out_valid || !out_stall;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ring pointer, read pointers and tap counter
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      coef_ptr   <= '0;
      issue_left <= '0;
    end else if (take_sample) begin
      wr_ptr     <= wr_ptr_next;
      rd_ptr     <= wr_ptr_next;
      coef_ptr   <= '0;
      issue_left <= taps_eff;
    end else if (issue_en) begin
      // walk from newest to older samples, coefficients from tap 0 up
      rd_ptr     <= (rd_ptr == '0) ? AW'(MAX_TAPS - 1) : rd_ptr - AW'(1);
      coef_ptr   <= coef_ptr + AW'(1);
      issue_left <= issue_left - CW'(1);
    end
  end

  // valid bits: entries never written read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      hist_vld <= '0;
      coef_vld <= '0;
    end else begin
      if (take_sample) begin
        hist_vld[wr_ptr_next] <= 1'b1;
      end
      if (take_coef) begin
        coef_vld[AW'(coef_index)] <= 1'b1;
      end
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (take_sample) begin
      hist_mem[wr_ptr_next] <= {sample_i, sample_q};
    end
    if (take_coef) begin
      coef_mem[AW'(coef_index)] <= coef_value;
    end
    if (issue_en) begin
      hist_rd     <= hist_mem[rd_ptr];
      hist_rd_vld <= hist_vld[rd_ptr];
      coef_rd     <= coef_mem[coef_ptr];
      coef_rd_vld <= coef_vld[coef_ptr];
    end
  end

  // pipeline stage flags
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ok   <= 1'b0;
      prod_ok <= 1'b0;
    end else begin
      rd_ok   <= issue_en;
      prod_ok <= rd_ok;
    end
  end

  assign tap_i = hist_rd_vld ? signed'(hist_rd[HW-1:SAMPLE_BITS]) : '0;
  assign tap_q = hist_rd_vld ? signed'(hist_rd[SAMPLE_BITS-1:0]) : '0;
  assign tap_c = coef_rd_vld ? signed'(coef_rd) : '0;

  // shared multiplier pair, registered before the accumulator
  always_ff @(posedge clk) begin
    if (rd_ok) begin
      prod_i <= tap_i * tap_c;
      prod_q <= tap_q * tap_c;
    end
  end

  // round-half-up term, none for a shift of zero
  assign round_term = (output_shift == '0) ? '0
                    : ACC_W'(1) <<< (output_shift - OUTPUT_SHIFT_W'(1));

  // accumulator, also takes the rounding term before the final shift
  always_ff @(posedge clk) begin
    if (take_sample) begin
      acc_i <= '0;
      acc_q <= '0;
    end else if (prod_ok) begin
      acc_i <= acc_i + ACC_W'(prod_i);
      acc_q <= acc_q + ACC_W'(prod_q);
    end else if (round_en) begin
      acc_i <= acc_i + round_term;
      acc_q <= acc_q + round_term;
    end
  end

  // arithmetic shift gives the floor, then clip to the sample range
  assign shift_i = acc_i >>> output_shift;
  assign shift_q = acc_q >>> output_shift;

  always_comb begin
    clip_i = 1'b1;
    clip_q = 1'b1;
    if (shift_i > SAT_HI) begin
      sat_i = SAT_HI[SAMPLE_BITS-1:0];
    end else if (shift_i < SAT_LO) begin
      sat_i = SAT_LO[SAMPLE_BITS-1:0];
    end else begin
      sat_i  = shift_i[SAMPLE_BITS-1:0];
      clip_i = 1'b0;
    end
    if (shift_q > SAT_HI) begin
      sat_q = SAT_HI[SAMPLE_BITS-1:0];
    end else if (shift_q < SAT_LO) begin
      sat_q = SAT_LO[SAMPLE_BITS-1:0];
    end else begin
      sat_q  = shift_q[SAMPLE_BITS-1:0];
      clip_q = 1'b0;
    end
  end

  // output register, holds the word until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_i     <= sat_i;
      out_q     <= sat_q;
      saturated <= clip_i || clip_q;
    end
  end

endmodule

// ===== tb/cfir_check_pkg.sv =====
// result prediction and checking for the complex fir filter testbench
`timescale 1ns / 1ps

package cfir_check_pkg;
  import cfir_pkg::*;

  localparam int     TAPS       = MAX_TAPS_DEF;
  localparam int     SW         = SAMPLE_BITS_DEF;
  localparam int     CW         = COEF_BITS_DEF;
  localparam longint SAT_HI     = (longint'(1) << (SW - 1)) - 1;
  localparam longint SAT_LO     = -SAT_HI - 1;

  typedef struct packed {
    logic signed [SW-1:0] re;
    logic signed [SW-1:0] im;
    logic                 clip;
  } fir_out_t;

  class fir_scoreboard;
    logic signed [SW-1:0]      hist_i [TAPS];
    logic signed [SW-1:0]      hist_q [TAPS];
    logic signed [CW-1:0]      coefs  [TAPS];
    logic [TAP_COUNT_W-1:0]    tap_count;
    logic [OUTPUT_SHIFT_W-1:0] out_shift;
    fir_out_t                  awaited [$];
    int                        errors;

    function new();
      foreach (hist_i[j]) begin
        hist_i[j] = '0;
        hist_q[j] = '0;
        coefs[j]  = '0;
      end
      tap_count = TAP_COUNT_RST;
      out_shift = OUTPUT_SHIFT_RST;
      errors    = 0;
    endfunction

    function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_TAP_COUNT) begin
        tap_count = data[TAP_COUNT_W-1:0];
      end else if (idx == REG_OUTPUT_SHIFT) begin
        out_shift = data[OUTPUT_SHIFT_W-1:0];
      end
    endfunction

    task mismatch(string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask

    // round half up, then shift right
    function longint rescale(longint acc);
      longint sum;
      sum = acc;
      if (out_shift != 0) begin
        sum += longint'(1) << (out_shift - 1);
      end
      return sum >>> out_shift;
    endfunction

    function logic signed [SW-1:0] clamp(longint v);
      if (v > SAT_HI) begin
        return SW'(SAT_HI);
      end else if (v < SAT_LO) begin
        return SW'(SAT_LO);
      end
      return SW'(v);
    endfunction

    function void note_word(logic k, logic signed [SW-1:0] si, logic signed [SW-1:0] sq,
                            logic [COEF_INDEX_W-1:0] ci, logic signed [CW-1:0] cv);
      longint   acc_i;
      longint   acc_q;
      longint   vi;
      longint   vq;
      int       n;
      int       j;
      fir_out_t e;
      if (k == KIND_COEF) begin
        coefs[ci] = cv;
        return;
      end
      // the whole line shifts, whatever the tap count
      for (j = TAPS - 1; j > 0; j--) begin
        hist_i[j] = hist_i[j-1];
        hist_q[j] = hist_q[j-1];
      end
      hist_i[0] = si;
      hist_q[0] = sq;
      if (tap_count == 0) begin
        n = 1;
      end else if (tap_count > TAPS) begin
        n = TAPS;
      end else begin
        n = int'(tap_count);
      end
      acc_i = 0;
      acc_q = 0;
      for (j = 0; j < n; j++) begin
        acc_i += longint'(hist_i[j]) * longint'(coefs[j]);
        acc_q += longint'(hist_q[j]) * longint'(coefs[j]);
      end
      vi = rescale(acc_i);
      vq = rescale(acc_q);
      e.re   = clamp(vi);
      e.im   = clamp(vq);
      e.clip = (vi > SAT_HI) || (vi < SAT_LO) || (vq > SAT_HI) || (vq < SAT_LO);
      awaited.push_back(e);
    endfunction

    task check_result(fir_out_t got);
      fir_out_t want;
      if (awaited.size() == 0) begin
        mismatch($sformatf("result word with nothing awaited: i=%0d q=%0d sat=%0b",
                           got.re, got.im, got.clip));
        return;
      end
      want = awaited.pop_front();
      if (got.re !== want.re) begin
        mismatch($sformatf("out_i got %0d, expected %0d", got.re, want.re));
      end
      if (got.im !== want.im) begin
        mismatch($sformatf("out_q got %0d, expected %0d", got.im, want.im));
      end
      if (got.clip !== want.clip) begin
        mismatch($sformatf("saturated got %0b, expected %0b", got.clip, want.clip));
      end
    endtask

    task flush();
      fir_out_t want;
      while (awaited.size() != 0) begin
        want = awaited.pop_front();
        mismatch($sformatf("result word never came: i=%0d q=%0d", want.re, want.im));
      end
    endtask
  endclass

endpackage

// ===== tb/tb_top.sv =====
// top level of the complex fir filter testbench: clock, reset, stimulus and result side
`timescale 1ns / 1ps

module tb_top;
  import cfir_pkg::*;
  import cfir_check_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  // settle time, longer than a sample pass over the full line
  localparam int SETTLE_CYCLES = 80;
  localparam int DRAIN_LIMIT   = 20_000;
  localparam int N_PHASES      = 12;
  localparam int PHASE_WORDS   = 155;
  localparam int HOLD_PHASE    = 5;
  localparam int CALM_PHASE    = 7;
  localparam int HOLD_CYCLES   = 500;
  localparam int IDLE_PCT      = 32;

  localparam logic signed [SW-1:0] S_MAX = {1'b0, {(SW - 1){1'b1}}};
  localparam logic signed [SW-1:0] S_MIN = {1'b1, {(SW - 1){1'b0}}};
  localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW - 1){1'b1}}};
  localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW - 1){1'b0}}};
  // 1.0 in q2.14
  localparam logic signed [CW-1:0] C_ONE = CW'(1 << (CW - 2));

  logic                      clk        = 1'b0;
  logic                      rst        = 1'b1;
  logic                      cfg_write  = 1'b0;
  logic [CFG_INDEX_W-1:0]    cfg_index  = '0;
  logic [CFG_DATA_W-1:0]     cfg_data   = '0;
  logic                      in_valid   = 1'b0;
  logic                      in_stall;
  logic                      kind       = KIND_SAMPLE;
  logic signed [SW-1:0]      sample_i   = '0;
  logic signed [SW-1:0]      sample_q   = '0;
  logic [COEF_INDEX_W-1:0]   coef_index = '0;
  logic signed [CW-1:0]      coef_value = '0;
  logic                      out_valid;
  logic                      out_stall  = 1'b0;
  logic signed [SW-1:0]      out_i;
  logic signed [SW-1:0]      out_q;
  logic                      saturated;

  // calm: no idling on either side; hold_asks: bumped to ask the result side for a long hold
  logic                      calm       = 1'b0;
  int                        hold_asks  = 0;
  int                        cycle_count = 0;

  fir_scoreboard             sb;

  complex_fir_filter u_top (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // hard stop in case the block hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // offer one word, with a random gap in front, and hold it until taken
  task automatic send_word(logic k, logic signed [SW-1:0] si, logic signed [SW-1:0] sq,
                           logic [COEF_INDEX_W-1:0] ci, logic signed [CW-1:0] cv);
    if (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < IDLE_PCT);
    end
    in_valid   <= 1'b1;
    kind       <= k;
    sample_i   <= si;
    sample_q   <= sq;
    coef_index <= ci;
    coef_value <= cv;
    // values read right after the edge are the ones the block saw at that edge
    do @(posedge clk); while (in_stall);
    sb.note_word(k, si, sq, ci, cv);
  endtask

  task automatic send_random_word();
    logic                 k;
    logic signed [SW-1:0] si;
    logic signed [SW-1:0] sq;
    logic signed [CW-1:0] cv;
    k  = ($urandom_range(99) < 30) ? KIND_COEF : KIND_SAMPLE;
    si = SW'($urandom);
    sq = SW'($urandom);
    // quieter samples and coefficients keep many sums inside the output range
    if ($urandom_range(3) == 0) begin
      si = si >>> 6;
      sq = sq >>> 6;
    end
    cv = CW'($urandom);
    if ($urandom_range(1) == 0) begin
      cv = cv >>> 5;
    end
    send_word(k, si, sq, COEF_INDEX_W'($urandom), cv);
  endtask

  // both registers, back to back, only while the block is idle
  task automatic set_config(logic [CFG_DATA_W-1:0] taps_data,
                            logic [CFG_DATA_W-1:0] shift_data);
    cfg_write <= 1'b1;
    cfg_index <= REG_TAP_COUNT;
    cfg_data  <= taps_data;
    @(posedge clk);
    sb.set_reg(REG_TAP_COUNT, taps_data);
    cfg_index <= REG_OUTPUT_SHIFT;
    cfg_data  <= shift_data;
    @(posedge clk);
    sb.set_reg(REG_OUTPUT_SHIFT, shift_data);
    cfg_write <= 1'b0;
  endtask

  // stop offering, wait for every awaited result word, then let a coefficient write settle
  task automatic wait_idle();
    int waited;
    in_valid <= 1'b0;
    waited = 0;
    while (sb.awaited.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // result side: check taken words, then pick the stall for the next cycle
  initial begin : result_side
    int       hold_left;
    int       hold_seen;
    fir_out_t got;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        got.re   = out_i;
        got.im   = out_q;
        got.clip = saturated;
        sb.check_result(got);
      end
      // long hold so the block fills up and pushes back on its input
      if (hold_asks != hold_seen) begin
        hold_seen = hold_asks;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  initial begin : stimulus
    int                    p;
    int                    n;
    logic [CFG_DATA_W-1:0] taps_data;
    logic [CFG_DATA_W-1:0] shift_data;
    sb = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed part, reset settings: 33 taps, shift 14
    // unity gain on the newest tap passes the sample extremes through
    send_word(KIND_COEF, SW'($urandom), SW'($urandom), 6'd0, C_ONE);
    send_word(KIND_SAMPLE, S_MAX, S_MIN, 6'($urandom), CW'($urandom));
    send_word(KIND_SAMPLE, S_MIN, S_MAX, 6'($urandom), CW'($urandom));
    send_word(KIND_SAMPLE, '0, '0, 6'($urandom), CW'($urandom));
    send_word(KIND_SAMPLE, SW'(1), SW'(-1), 6'($urandom), CW'($urandom));
    // coefficient extremes drive both parts into saturation
    send_word(KIND_COEF, SW'($urandom), SW'($urandom), 6'd0, C_MAX);
    send_word(KIND_COEF, SW'($urandom), SW'($urandom), 6'd1, C_MIN);
    send_word(KIND_SAMPLE, S_MAX, S_MAX, 6'($urandom), CW'($urandom));
    send_word(KIND_SAMPLE, S_MIN, S_MIN, 6'($urandom), CW'($urandom));
    send_word(KIND_SAMPLE, S_MAX, S_MIN, 6'($urandom), CW'($urandom));
    // last active tap, first inactive tap and the top of the table
    send_word(KIND_COEF, SW'($urandom), SW'($urandom), 6'd32, CW'(-1));
    send_word(KIND_COEF, SW'($urandom), SW'($urandom), 6'd33, C_MAX);
    send_word(KIND_COEF, SW'($urandom), SW'($urandom), 6'd63, C_MIN);
    send_word(KIND_SAMPLE, SW'(-1), SW'(1), 6'($urandom), CW'($urandom));
    // exact half steps: positive rounds up, negative rounds toward zero
    send_word(KIND_COEF, SW'($urandom), SW'($urandom), 6'd0, CW'(1));
    send_word(KIND_COEF, SW'($urandom), SW'($urandom), 6'd1, '0);
    send_word(KIND_COEF, SW'($urandom), SW'($urandom), 6'd32, '0);
    send_word(KIND_SAMPLE, SW'(8192), SW'(-8192), 6'($urandom), CW'($urandom));
    send_word(KIND_SAMPLE, SW'(24576), SW'(-24576), 6'($urandom), CW'($urandom));
    send_word(KIND_SAMPLE, S_MIN, S_MAX, 6'($urandom), CW'($urandom));
    wait_idle();

    // random phases, each under its own settings
    for (p = 0; p < N_PHASES; p++) begin
      case (p)
        0: begin
          // single tap, no rounding at all
          taps_data  = 7'd1;
          shift_data = 7'd0;
        end
        1: begin
          // full line, widest shift
          taps_data  = 7'd64;
          shift_data = 7'd31;
        end
        2: begin
          // zero taps behaves as one
          taps_data  = 7'd0;
          shift_data = 7'd14;
        end
        3: begin
          // every tap-count bit set, clipped to the full line
          taps_data  = 7'd127;
          shift_data = 7'd15;
        end
        4: begin
          taps_data  = 7'd65;
          shift_data = 7'd12;
        end
        HOLD_PHASE: begin
          taps_data  = 7'd4;
          shift_data = 7'd2;
        end
        default: begin
          taps_data  = ($urandom_range(3) == 0) ? CFG_DATA_W'($urandom)
                                                : CFG_DATA_W'($urandom_range(1, 16));
          // upper data bits are junk for the shift register
          shift_data = {2'($urandom), 5'($urandom_range(9, 20))};
          if ($urandom_range(3) == 0) begin
            shift_data = CFG_DATA_W'($urandom);
          end
        end
      endcase
      set_config(taps_data, shift_data);
      calm = (p == CALM_PHASE);
      for (n = 0; n < PHASE_WORDS; n++) begin
        if (p == HOLD_PHASE && n == 20) begin
          hold_asks++;
        end
        send_random_word();
      end
      wait_idle();
    end

    sb.flush();
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
